>>> src/lrcc_pkg.sv
// ----------------------------------------------------------------------------
// lrcc_pkg
// Shared types, constants and the CRC-32 byte update for the log record
// CRC prefix checker.
// ----------------------------------------------------------------------------
package lrcc_pkg;

    localparam int OUT_W = 40;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_CRC  = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] valid_end;
        logic [OUT_W-1:0] total_size;
        logic             torn;
    } result_t;

    // reflected crc-32, one byte folded in bit by bit
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> src/lrcc_feed_if.sv
// ----------------------------------------------------------------------------
// lrcc_feed_if
// Byte stream channel into the checker.
// ----------------------------------------------------------------------------
interface lrcc_feed_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_item;

    modport source (output valid, data_byte, has_byte, last_item, input ready);
    modport sink   (input valid, data_byte, has_byte, last_item, output ready);
endinterface

>>> src/lrcc_report_if.sv
// ----------------------------------------------------------------------------
// lrcc_report_if
// Per-file result channel out of the checker.
// ----------------------------------------------------------------------------
interface lrcc_report_if;
    logic        valid;
    logic        ready;
    logic [39:0] valid_end;
    logic [39:0] total_size;
    logic        torn;

    modport source (output valid, valid_end, total_size, torn, input ready);
    modport sink   (input valid, valid_end, total_size, torn, output ready);
endinterface

>>> src/log_record_crc_prefix_checker.sv
// ----------------------------------------------------------------------------
// log_record_crc_prefix_checker
// Scans a log file byte by byte, checks CRC-32 length-prefixed records and
// reports the end of the longest verified prefix, the file size and a torn
// flag on the last beat of each file.
//
//   channel  dir  beat contents                          when
//   feed     in   data_byte, has_byte, last_item         up to one byte per beat
//   report   out  valid_end, total_size, torn            one per file
//
// one beat per cycle unless a stalled report holds a last beat; a beat is
// registered first, then the parser state and result register update together.
// reset clears the input stage, the parser state and the result valid.
// only a last beat waits on the result register: a stalled report blocks the
// next file's end, ordinary bytes keep flowing.
// ----------------------------------------------------------------------------
module log_record_crc_prefix_checker #(
    parameter int OFFSET_BITS = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    lrcc_feed_if.sink    feed,
    lrcc_report_if.source report
);
    import lrcc_pkg::*;

    item_t   s1_item_reg;
    logic    s1_valid_reg, s1_valid_next;
    logic    s1_advance;
    logic    step;
    result_t scan_result;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;

    assign s1_advance = !s1_item_reg.last_item || !out_valid_reg || report.ready;
    assign step       = s1_valid_reg && s1_advance;
    assign feed.ready = !s1_valid_reg || s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (feed.valid && feed.ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && s1_item_reg.last_item)
        begin
            out_valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed.valid && feed.ready)
        begin
            s1_item_reg.data_byte <= feed.data_byte;
            s1_item_reg.has_byte  <= feed.has_byte;
            s1_item_reg.last_item <= feed.last_item;
        end
        if (step && s1_item_reg.last_item)
        begin
            out_reg <= scan_result;
        end
    end

    lrcc_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (s1_item_reg),
        .result (scan_result)
    );

    assign report.valid      = out_valid_reg;
    assign report.valid_end  = out_reg.valid_end;
    assign report.total_size = out_reg.total_size;
    assign report.torn       = out_reg.torn;

endmodule

>>> src/lrcc_scan.sv
// ----------------------------------------------------------------------------
// lrcc_scan
// Record parser state: byte counter, verified end, field tracking and the
// running CRC. Advances one item per step and presents the file result.
// ----------------------------------------------------------------------------
module lrcc_scan #(
    parameter int OFFSET_BITS = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  lrcc_pkg::item_t   item,
    output lrcc_pkg::result_t result
);
    import lrcc_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    logic [OFFSET_BITS-1:0] byte_count_reg, byte_count_next;
    logic [OFFSET_BITS-1:0] good_end_reg, good_end_next;
    phase_t                 phase_reg, phase_next;
    logic [1:0]             field_index_reg, field_index_next;
    logic [31:0]            expected_crc_reg, expected_crc_next;
    logic [31:0]            record_length_reg, record_length_next;
    logic [31:0]            bytes_left_reg, bytes_left_next;
    logic [31:0]            running_crc_reg, running_crc_next;

    logic [31:0]            crc_upd;
    logic [31:0]            lane;
    logic [31:0]            len_full;
    logic [31:0]            left_dec;
    logic                   rec_end;
    logic [63:0]            good_ext;
    logic [63:0]            count_ext;

    assign crc_upd  = crc_byte(running_crc_reg, item.data_byte);
    assign lane     = 32'(item.data_byte) << {field_index_reg, 3'b000};
    assign len_full = record_length_reg | lane;
    assign left_dec = bytes_left_reg - 32'd1;

    always_comb
    begin
        byte_count_next    = byte_count_reg;
        good_end_next      = good_end_reg;
        phase_next         = phase_reg;
        field_index_next   = field_index_reg;
        expected_crc_next  = expected_crc_reg;
        record_length_next = record_length_reg;
        bytes_left_next    = bytes_left_reg;
        running_crc_next   = running_crc_reg;
        rec_end            = 1'b0;

        if (item.has_byte)
        begin
            if (byte_count_reg != OFFSET_MAX)
            begin
                byte_count_next = byte_count_reg + OFFSET_BITS'(1);
            end

            unique case (phase_reg)
                PH_CRC:
                begin
                    expected_crc_next = expected_crc_reg | lane;
                    if (field_index_reg == 2'd3)
                    begin
                        field_index_next   = 2'd0;
                        record_length_next = 32'd0;
                        phase_next         = PH_LEN;
                    end
                    else
                    begin
                        field_index_next = field_index_reg + 2'd1;
                    end
                end
                PH_LEN:
                begin
                    running_crc_next   = crc_upd;
                    record_length_next = len_full;
                    if (field_index_reg == 2'd3)
                    begin
                        field_index_next = 2'd0;
                        bytes_left_next  = len_full;
                        if (len_full == 32'd0)
                        begin
                            rec_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PAY;
                        end
                    end
                    else
                    begin
                        field_index_next = field_index_reg + 2'd1;
                    end
                end
                PH_PAY:
                begin
                    running_crc_next = crc_upd;
                    bytes_left_next  = left_dec;
                    if (left_dec == 32'd0)
                    begin
                        rec_end = 1'b1;
                    end
                end
                PH_STOP:
                begin
                end
                default:
                begin
                end
            endcase

            if (rec_end)
            begin
                if ((crc_upd ^ CRC_ONES) == expected_crc_reg)
                begin
                    good_end_next     = byte_count_next;
                    phase_next        = PH_CRC;
                    field_index_next  = 2'd0;
                    running_crc_next  = CRC_ONES;
                    expected_crc_next = 32'd0;
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
        end
    end

    assign good_ext          = 64'(good_end_next);
    assign count_ext         = 64'(byte_count_next);
    assign result.valid_end  = good_ext[OUT_W-1:0];
    assign result.total_size = count_ext[OUT_W-1:0];
    assign result.torn       = (good_end_next != byte_count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            good_end_reg      <= '0;
            phase_reg         <= PH_CRC;
            field_index_reg   <= 2'd0;
            expected_crc_reg  <= 32'd0;
            record_length_reg <= 32'd0;
            bytes_left_reg    <= 32'd0;
            running_crc_reg   <= CRC_ONES;
        end
        else if (step)
        begin
            if (item.last_item)
            begin
                // end of file: back to the start state for the next file
                byte_count_reg    <= '0;
                good_end_reg      <= '0;
                phase_reg         <= PH_CRC;
                field_index_reg   <= 2'd0;
                expected_crc_reg  <= 32'd0;
                record_length_reg <= 32'd0;
                bytes_left_reg    <= 32'd0;
                running_crc_reg   <= CRC_ONES;
            end
            else
            begin
                byte_count_reg    <= byte_count_next;
                good_end_reg      <= good_end_next;
                phase_reg         <= phase_next;
                field_index_reg   <= field_index_next;
                expected_crc_reg  <= expected_crc_next;
                record_length_reg <= record_length_next;
                bytes_left_reg    <= bytes_left_next;
                running_crc_reg   <= running_crc_next;
            end
        end
    end

endmodule
